### hw/rtl/ksum_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksum_pkg
// shared widths, codes and control structs of the sorted union merge unit
// ----------------------------------------------------------------------------
package ksum_pkg;

   localparam int DATA_W         = 32;
   localparam int LIST_NUM_W     = 3;
   localparam int ACTION_W       = 2;
   localparam int REQ_TDATA_W    = 40;
   localparam int RSP_TDATA_W    = 40;

   localparam int DEF_MAX_LISTS  = 8;
   localparam int DEF_LIST_DEPTH = 256;

   // request kinds carried in req_tuser
   localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_PULL  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   // commands to the list head and fill table
   typedef struct packed {
      logic clear;
      logic append;
      logic advance;
   } list_cmd_type;

   // commands to the shared minimum unit
   typedef struct packed {
      logic clear;
      logic step;
   } min_cmd_type;

endpackage

### hw/rtl/ksum_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksum_store
// element memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module ksum_store #(
   parameter int DEPTH  = ksum_pkg::DEF_MAX_LISTS * ksum_pkg::DEF_LIST_DEPTH,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [ksum_pkg::DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [ksum_pkg::DATA_W-1:0] rd_data
);

   logic [ksum_pkg::DATA_W-1:0] mem [DEPTH];
   logic [ksum_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/ksum_list_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksum_list_table
// per-list fill counts and head positions
// ----------------------------------------------------------------------------
module ksum_list_table #(
   parameter int MAX_LISTS  = ksum_pkg::DEF_MAX_LISTS,
   parameter int LIST_DEPTH = ksum_pkg::DEF_LIST_DEPTH,
   parameter int LW         = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1,
   parameter int CNT_W      = $clog2(LIST_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ksum_pkg::list_cmd_type cmd,
   input  logic [LW-1:0]         sel,
   input  logic [MAX_LISTS-1:0]  adv_mask,
   output logic [CNT_W-1:0]      sel_fill,
   output logic [CNT_W-1:0]      sel_head,
   output logic [MAX_LISTS-1:0]  has_values
);

   logic [CNT_W-1:0] fill_ff [MAX_LISTS];
   logic [CNT_W-1:0] fill_in [MAX_LISTS];
   logic [CNT_W-1:0] head_ff [MAX_LISTS];
   logic [CNT_W-1:0] head_in [MAX_LISTS];

   always_comb begin
      for (int k = 0; k < MAX_LISTS; k++) begin
         fill_in[k] = fill_ff[k];
         head_in[k] = head_ff[k];
         if (cmd.clear) begin
            fill_in[k] = '0;
            head_in[k] = '0;
         end else begin
            if (cmd.append && (sel == LW'(k))) begin
               fill_in[k] = fill_ff[k] + CNT_W'(1);
            end
            if (cmd.advance && adv_mask[k]) begin
               head_in[k] = head_ff[k] + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_LISTS; k++) begin
            fill_ff[k] <= '0;
            head_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < MAX_LISTS; k++) begin
            fill_ff[k] <= fill_in[k];
            head_ff[k] <= head_in[k];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < MAX_LISTS; k++) begin
         has_values[k] = (head_ff[k] != fill_ff[k]);
      end
   end

   assign sel_fill = fill_ff[sel];
   assign sel_head = head_ff[sel];

endmodule

### hw/rtl/ksum_min_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksum_min_unit
// shared signed comparator, keeps the running minimum and its match mask
// ----------------------------------------------------------------------------
module ksum_min_unit #(
   parameter int MAX_LISTS = ksum_pkg::DEF_MAX_LISTS,
   parameter int LW        = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ksum_pkg::min_cmd_type       cmd,
   input  logic [LW-1:0]               idx,
   input  logic [ksum_pkg::DATA_W-1:0] value,
   output logic                        found,
   output logic [ksum_pkg::DATA_W-1:0] best,
   output logic [MAX_LISTS-1:0]        match_mask
);

   logic                        found_ff, found_in;
   logic [ksum_pkg::DATA_W-1:0] best_ff, best_in;
   logic [MAX_LISTS-1:0]        mask_ff, mask_in;
   logic [MAX_LISTS-1:0]        idx_bit;
   logic                        is_less;
   logic                        is_equal;

   assign is_less  = $signed(value) < $signed(best_ff);
   assign is_equal = (value == best_ff);

   always_comb begin
      for (int k = 0; k < MAX_LISTS; k++) begin
         idx_bit[k] = (idx == LW'(k));
      end
   end

   always_comb begin
      found_in = found_ff;
      best_in  = best_ff;
      mask_in  = mask_ff;
      if (cmd.clear) begin
         found_in = 1'b0;
         mask_in  = '0;
      end else if (cmd.step) begin
         if (!found_ff || is_less) begin
            found_in = 1'b1;
            best_in  = value;
            mask_in  = idx_bit;
         end else if (is_equal) begin
            mask_in  = mask_ff | idx_bit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         mask_ff  <= '0;
      end else begin
         found_ff <= found_in;
         mask_ff  <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
   end

   assign found      = found_ff;
   assign best       = best_ff;
   assign match_mask = mask_ff;

endmodule

### hw/rtl/kway_sorted_union_merge_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kway_sorted_union_merge_unit
// multiway merge of ascending signed lists into one ascending union stream
// ----------------------------------------------------------------------------
// Each request transfer carries a kind in req_tuser: load appends a signed
// value to a list, pull emits the next value of the merged union, clear
// empties every list and the sticky overflow flag. Load and clear finish in
// the cycle of their transfer and give no response, so they can be sent
// back to back. A pull gives exactly one response and holds the request side
// until that response is registered: the single memory read port and the
// single comparator walk the list heads one per cycle, then the matching
// heads advance and the response is formed.
// Equal heads of different lists come out once; duplicates inside one list
// come out once per pull. A load to a full list is dropped and raises the
// overflow flag; a list number of MAX_LISTS or more is ignored. The element
// memory is not cleared: only entries that have been written are ever read,
// so no clearing pass follows reset. Responses sit in an output register,
// so loads are still taken while a response waits for rsp_tready.
// ----------------------------------------------------------------------------
module kway_sorted_union_merge_unit #(
   parameter int MAX_LISTS  = ksum_pkg::DEF_MAX_LISTS,
   parameter int LIST_DEPTH = ksum_pkg::DEF_LIST_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [2:0] list_number, [34:3] element_value, [39:35] zero
   input  logic [ksum_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [1:0] action
   input  logic [ksum_pkg::ACTION_W-1:0]    req_tuser,
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [31:0] merged_value, [32] overflow, [39:33] zero
   output logic [ksum_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // [0] valid_res
   output logic                             rsp_tuser,
   // final_value
   output logic                             rsp_tlast
);

   localparam int LW     = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int DEPTH  = MAX_LISTS * LIST_DEPTH;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DW     = ksum_pkg::DATA_W;
   localparam int NW     = ksum_pkg::LIST_NUM_W;

   // one-hot sequencer states
   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_SCAN    = 5'b00010,
      ST_DRAIN   = 5'b00100,
      ST_ADVANCE = 5'b01000,
      ST_REPLY   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // request fields
   logic [NW-1:0] req_list;
   logic [DW-1:0] req_value;
   logic          req_xfer;
   logic          list_in_range;

   assign req_list  = req_tdata[NW-1:0];
   assign req_value = req_tdata[NW+DW-1:NW];
   assign req_xfer  = req_tvalid && req_tready;
   assign list_in_range = (32'(req_list) < MAX_LISTS);

   // scan position and the issue stage in front of the memory read
   logic [LW-1:0] scan_ff, scan_in;
   logic          iss_valid_ff, iss_valid_in;
   logic [LW-1:0] iss_idx_ff;

   logic          overflow_ff, overflow_in;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_value_ff;
   logic          rsp_ok_ff;
   logic          rsp_last_ff;
   logic          rsp_ovf_ff;

   // list table
   ksum_pkg::list_cmd_type lcmd;
   logic [LW-1:0]          sel;
   logic [CNT_W-1:0]       sel_fill;
   logic [CNT_W-1:0]       sel_head;
   logic [MAX_LISTS-1:0]   has_values;

   // minimum unit
   ksum_pkg::min_cmd_type  mcmd;
   logic                   found;
   logic [DW-1:0]          best;
   logic [MAX_LISTS-1:0]   match_mask;

   // memory
   logic                   wr_en;
   logic [ADDR_W-1:0]      list_base;
   logic [ADDR_W-1:0]      wr_addr;
   logic [ADDR_W-1:0]      rd_addr;
   logic [DW-1:0]          rd_data;

   logic                   is_load;
   logic                   list_full;

   // list select: the addressed list while idle, the scan position otherwise
   assign sel       = state_ff[0] ? LW'(req_list) : scan_ff;
   assign list_base = ADDR_W'(sel) * ADDR_W'(LIST_DEPTH);
   assign wr_addr   = list_base + ADDR_W'(sel_fill);
   assign rd_addr   = list_base + ADDR_W'(sel_head);
   assign list_full = (sel_fill == CNT_W'(LIST_DEPTH));

   assign is_load = req_xfer && (req_tuser == ksum_pkg::ACT_LOAD) && list_in_range;
   assign wr_en   = is_load && !list_full;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      iss_valid_in = 1'b0;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      lcmd         = '0;
      mcmd         = '0;

      // the comparator sees each read in the cycle after its address
      mcmd.step = iss_valid_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_tuser)
                  ksum_pkg::ACT_LOAD: begin
                     if (list_in_range) begin
                        if (list_full) begin
                           overflow_in = 1'b1;
                        end else begin
                           lcmd.append = 1'b1;
                        end
                     end
                  end
                  ksum_pkg::ACT_PULL: begin
                     mcmd.clear = 1'b1;
                     scan_in    = '0;
                     state_in   = ST_SCAN;
                  end
                  ksum_pkg::ACT_CLEAR: begin
                     lcmd.clear  = 1'b1;
                     overflow_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // read the head of this list if it still holds values
            iss_valid_in = has_values[scan_ff];
            if (scan_ff == LW'(MAX_LISTS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               scan_in = scan_ff + LW'(1);
            end
         end
         ST_DRAIN: begin
            // last head goes through the comparator
            state_in = ST_ADVANCE;
         end
         ST_ADVANCE: begin
            lcmd.advance = 1'b1;
            state_in     = ST_REPLY;
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ff      <= '0;
         iss_valid_ff <= 1'b0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         iss_valid_ff <= iss_valid_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      iss_idx_ff <= scan_ff;
      if ((state_ff == ST_REPLY) && (!rsp_valid_ff || rsp_tready)) begin
         rsp_value_ff <= found ? best : '0;
         rsp_ok_ff    <= found;
         // heads have already advanced, so has_values is the state after this value
         rsp_last_ff  <= found && !(|has_values);
         rsp_ovf_ff   <= overflow_ff;
      end
   end

   ksum_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ksum_list_table #(
      .MAX_LISTS  (MAX_LISTS),
      .LIST_DEPTH (LIST_DEPTH),
      .LW         (LW),
      .CNT_W      (CNT_W)
   ) u_list_table (
      .clock      (clock),
      .reset      (reset),
      .cmd        (lcmd),
      .sel        (sel),
      .adv_mask   (match_mask),
      .sel_fill   (sel_fill),
      .sel_head   (sel_head),
      .has_values (has_values)
   );

   ksum_min_unit #(
      .MAX_LISTS (MAX_LISTS),
      .LW        (LW)
   ) u_min_unit (
      .clock      (clock),
      .reset      (reset),
      .cmd        (mcmd),
      .idx        (iss_idx_ff),
      .value      (rd_data),
      .found      (found),
      .best       (best),
      .match_mask (match_mask)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(ksum_pkg::RSP_TDATA_W - DW - 1)'(0), rsp_ovf_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### tb/tb_kway_sorted_union_merge_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kway_sorted_union_merge_unit
// self-checking bench for the multiway sorted union merge unit
// ----------------------------------------------------------------------------
// Load, pull, clear and spare-code transfers go in on the request stream. A
// copy of the list store, heads and overflow flag inside the bench works out
// each pull response, which is checked field by field as it leaves. Runs
// cover hand-picked corner cases, a full list, then sorted random lists
// under several patterns of sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_kway_sorted_union_merge_unit;

   localparam int MAX_LISTS   = ksum_pkg::DEF_MAX_LISTS;
   localparam int LIST_DEPTH  = ksum_pkg::DEF_LIST_DEPTH;
   localparam int DATA_W      = ksum_pkg::DATA_W;
   localparam int ACTION_W    = ksum_pkg::ACTION_W;
   localparam int LIST_NUM_W  = ksum_pkg::LIST_NUM_W;
   localparam int REQ_TDATA_W = ksum_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W = ksum_pkg::RSP_TDATA_W;
   localparam int QUIET_LIMIT = 5000;   // cycles with no transfer on either side
   localparam int DRAIN_CYCLES = 20;
   localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

   typedef struct packed {
      logic [DATA_W-1:0] merged;
      logic              emitted;
      logic              last;
      logic              ovf;
   } merge_result_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [ACTION_W-1:0]    req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;

   // bench copy of the list store
   logic [DATA_W-1:0] list_mem [MAX_LISTS][LIST_DEPTH];
   int                fill_cnt [MAX_LISTS];
   int                head_idx [MAX_LISTS];
   logic              ovf_flag = 1'b0;

   merge_result_type union_results_q [$];

   int items_sent     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatches     = 0;
   int quiet_cycles   = 0;

   kway_sorted_union_merge_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      for (int k = 0; k < MAX_LISTS; k++) begin
         fill_cnt[k] = 0;
         head_idx[k] = 0;
      end
   end

   // one transfer into the bench copy; a pull queues its response
   function automatic void predict_union_step(input logic [ACTION_W-1:0] act,
                                              input logic [LIST_NUM_W-1:0] lst,
                                              input logic [DATA_W-1:0] val);
      logic [DATA_W-1:0] best;
      logic [DATA_W-1:0] head;
      bit                found;
      bit                remaining;
      merge_result_type  res;
      found     = 1'b0;
      remaining = 1'b0;
      best      = '0;
      case (act)
         ksum_pkg::ACT_LOAD: begin
            if (lst < MAX_LISTS) begin
               if (fill_cnt[lst] >= LIST_DEPTH) begin
                  ovf_flag = 1'b1;
               end else begin
                  list_mem[lst][fill_cnt[lst]] = val;
                  fill_cnt[lst]++;
               end
            end
         end
         ksum_pkg::ACT_CLEAR: begin
            for (int k = 0; k < MAX_LISTS; k++) begin
               fill_cnt[k] = 0;
               head_idx[k] = 0;
            end
            ovf_flag = 1'b0;
         end
         ksum_pkg::ACT_PULL: begin
            for (int k = 0; k < MAX_LISTS; k++) begin
               if (head_idx[k] < fill_cnt[k]) begin
                  head = list_mem[k][head_idx[k]];
                  if (!found || $signed(head) < $signed(best)) begin
                     best  = head;
                     found = 1'b1;
                  end
               end
            end
            if (found) begin
               // every head equal to the minimum moves on together
               for (int k = 0; k < MAX_LISTS; k++) begin
                  if (head_idx[k] < fill_cnt[k] && list_mem[k][head_idx[k]] == best)
                     head_idx[k]++;
               end
               for (int k = 0; k < MAX_LISTS; k++) begin
                  if (head_idx[k] < fill_cnt[k])
                     remaining = 1'b1;
               end
            end
            res.merged  = found ? best : '0;
            res.emitted = found;
            res.last    = found && !remaining;
            res.ovf     = ovf_flag;
            union_results_q.insert(union_results_q.size(), res);
         end
         default: ;
      endcase
   endfunction

   task automatic send_item(input logic [ACTION_W-1:0] act,
                            input logic [LIST_NUM_W-1:0] lst,
                            input logic [DATA_W-1:0] val);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {{(REQ_TDATA_W - DATA_W - LIST_NUM_W){1'b0}}, val, lst};
      do @(posedge clock); while (!req_tready);
      predict_union_step(act, lst, val);
      if (act != ACT_SPARE)
         items_sent++;
   endtask

   task automatic pull_once();
      send_item(ksum_pkg::ACT_PULL, LIST_NUM_W'($urandom_range(0, MAX_LISTS - 1)), $urandom);
   endtask

   // sender goes quiet until every queued response has left
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (union_results_q.size() != 0);
   endtask

   task automatic set_idling(input int idle_pct, input int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
   endtask

   // extremes, equal heads across lists, duplicates in one list, unsorted
   // list, load after pulls, spare action code, pulls on empty lists
   task automatic test_directed_cases();
      pull_once();
      send_item(ksum_pkg::ACT_LOAD, 3'd0, 32'h8000_0000);
      send_item(ksum_pkg::ACT_LOAD, 3'd0, 32'h0000_0000);
      send_item(ksum_pkg::ACT_LOAD, 3'd7, 32'hffff_ffff);
      send_item(ksum_pkg::ACT_LOAD, 3'd7, 32'h7fff_ffff);
      send_item(ksum_pkg::ACT_LOAD, 3'd3, 32'h0000_0000);
      send_item(ksum_pkg::ACT_LOAD, 3'd3, 32'h0000_0000);
      send_item(ksum_pkg::ACT_LOAD, 3'd5, 32'h0000_0000);
      send_item(ksum_pkg::ACT_LOAD, 3'd2, 32'd5);
      send_item(ksum_pkg::ACT_LOAD, 3'd2, 32'd3);
      send_item(ACT_SPARE, 3'd6, 32'h1234_5678);
      pull_once();
      pull_once();
      send_item(ksum_pkg::ACT_LOAD, 3'd1, 32'd4);
      repeat (6) pull_once();
      pull_once();
      send_item(ksum_pkg::ACT_CLEAR, 3'd0, 32'hffff_ffff);
      pull_once();
   endtask

   // one list filled to the brim, then two dropped loads
   task automatic test_full_list_overflow();
      logic [DATA_W-1:0] v;
      send_item(ksum_pkg::ACT_CLEAR, 3'd0, 32'd0);
      for (int i = 0; i < LIST_DEPTH; i++) begin
         v = i * 4 - 512;
         send_item(ksum_pkg::ACT_LOAD, 3'd4, v);
      end
      send_item(ksum_pkg::ACT_LOAD, 3'd4, 32'h7fff_fff0);
      send_item(ksum_pkg::ACT_LOAD, 3'd4, 32'h8000_0000);
      send_item(ksum_pkg::ACT_LOAD, 3'd1, -32'sd600);
      for (int i = 0; i < 4; i++) begin
         pull_once();
         wait_results_drained();
      end
      repeat (4) pull_once();
      send_item(ksum_pkg::ACT_CLEAR, 3'd0, 32'd0);
      send_item(ksum_pkg::ACT_LOAD, 3'd4, 32'd9);
      pull_once();
      pull_once();
   endtask

   // mostly well-formed merges: sorted lists loaded interleaved, then pulled
   // out; the rest is noise with any action, list and value
   task automatic test_random_merges(input int budget);
      logic [DATA_W-1:0] seq_vals [MAX_LISTS][16];
      int                seq_len [MAX_LISTS];
      int                seq_pos [MAX_LISTS];
      logic [DATA_W-1:0] v;
      int                start;
      int                total;
      int                mode;
      int                j;
      int                pick;
      int                left;
      start = items_sent;
      while (items_sent - start < budget) begin
         if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 6))
               send_item(ACTION_W'($urandom_range(0, 3)),
                         LIST_NUM_W'($urandom_range(0, MAX_LISTS - 1)), $urandom);
         end else begin
            if ($urandom_range(0, 99) < 35)
               send_item(ksum_pkg::ACT_CLEAR,
                         LIST_NUM_W'($urandom_range(0, MAX_LISTS - 1)), $urandom);
            mode  = $urandom_range(0, 2);
            total = 0;
            for (int k = 0; k < MAX_LISTS; k++) begin
               seq_len[k] = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 10) : 0;
               seq_pos[k] = 0;
               for (int i = 0; i < seq_len[k]; i++) begin
                  case (mode)
                     0: v = $urandom_range(0, 12) - 6;   // narrow range, many equal heads
                     1: v = $urandom;
                     default: begin
                        case ($urandom_range(0, 4))
                           0: v = 32'h8000_0000;
                           1: v = 32'h7fff_ffff;
                           2: v = 32'hffff_ffff;
                           3: v = 32'h0000_0000;
                           default: v = $urandom;
                        endcase
                     end
                  endcase
                  // insertion keeps each list ascending
                  j = i;
                  while (j > 0 && $signed(seq_vals[k][j-1]) > $signed(v)) begin
                     seq_vals[k][j] = seq_vals[k][j-1];
                     j--;
                  end
                  seq_vals[k][j] = v;
               end
               total += seq_len[k];
            end
            left = total;
            while (left > 0) begin
               pick = $urandom_range(0, MAX_LISTS - 1);
               while (seq_pos[pick] == seq_len[pick])
                  pick = (pick + 1) % MAX_LISTS;
               send_item(ksum_pkg::ACT_LOAD, LIST_NUM_W'(pick), seq_vals[pick][seq_pos[pick]]);
               seq_pos[pick]++;
               left--;
            end
            repeat (total + $urandom_range(0, 2)) begin
               if ($urandom_range(0, 99) < 5)
                  send_item(ksum_pkg::ACT_LOAD,
                            LIST_NUM_W'($urandom_range(0, MAX_LISTS - 1)), $urandom);
               pull_once();
            end
         end
      end
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : check_results
      merge_result_type got;
      merge_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[DATA_W-1:0], rsp_tuser, rsp_tlast, rsp_tdata[DATA_W]};
         if (union_results_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response value %h valid %b last %b ovf %b", $time,
                     got.merged, got.emitted, got.last, got.ovf);
         end else begin
            want = union_results_q.pop_front();
            if (got.merged !== want.merged || got.emitted !== want.emitted ||
                got.last !== want.last || got.ovf !== want.ovf) begin
               mismatches++;
               $display("%0t: response mismatch: expected value %h valid %b last %b ovf %b",
                        $time, want.merged, want.emitted, want.last, want.ovf);
               $display("%0t:                    actual   value %h valid %b last %b ovf %b",
                        $time, got.merged, got.emitted, got.last, got.ovf);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idling(0, 0);
      test_directed_cases();
      test_full_list_overflow();

      set_idling(0, 0);
      test_random_merges(110);
      set_idling(71, 0);
      test_random_merges(110);
      set_idling(0, 71);
      test_random_merges(110);
      set_idling(13, 13);
      test_random_merges(110);

      set_idling(0, 0);
      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/ksum_pkg.sv
hw/rtl/ksum_store.sv
hw/rtl/ksum_list_table.sv
hw/rtl/ksum_min_unit.sv
hw/rtl/kway_sorted_union_merge_unit.sv
tb/tb_kway_sorted_union_merge_unit.sv
